// File: src/sac_pkg.sv
// Shared types and constants for the swept box collision unit.
`default_nettype none
package sac_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [1:0] NRM_NONE = 2'sb00;
  localparam logic signed [1:0] NRM_POS  = 2'sb01;
  localparam logic signed [1:0] NRM_NEG  = 2'sb11;

  typedef struct packed {
    logic active;
    logic vx_zero;
    logic vy_zero;
    logic xe_neg;
    logic xx_neg;
    logic ye_neg;
    logic yx_neg;
    logic xie_neg;
    logic yie_neg;
  } sac_flags_t;

endpackage
`default_nettype wire

// File: src/sac_front.sv
// Front end: takes a box pair, runs the broadphase and forms the per-axis distances.
`default_nettype none
module sac_front import sac_pkg::*; #(
  parameter int CB = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 take_i,
  input  wire logic signed [CB-1:0] a_left_i,
  input  wire logic signed [CB-1:0] a_top_i,
  input  wire logic signed [CB-1:0] a_right_i,
  input  wire logic signed [CB-1:0] a_bottom_i,
  input  wire logic signed [CB-1:0] b_left_i,
  input  wire logic signed [CB-1:0] b_top_i,
  input  wire logic signed [CB-1:0] b_right_i,
  input  wire logic signed [CB-1:0] b_bottom_i,
  input  wire logic signed [CB-1:0] vel_x_i,
  input  wire logic signed [CB-1:0] vel_y_i,
  input  wire logic                 a_movable_i,
  output logic                      valid_o,
  output sac_flags_t                flags_o,
  output logic [CB:0]               nxe_o,
  output logic [CB:0]               nxx_o,
  output logic [CB:0]               nye_o,
  output logic [CB:0]               nyx_o,
  output logic [CB-1:0]             dx_o,
  output logic [CB-1:0]             dy_o,
  output logic signed [CB-1:0]      vx_o,
  output logic signed [CB-1:0]      vy_o
);

  logic signed [CB:0] al, at, ar, ab, bl, bt, br, bb, vx, vy;
  logic signed [CB:0] sl, sr, st, sb, alv, arv, atv, abv;
  logic signed [CB:0] xie, xex, yie, yex;
  logic               broad;
  logic               valid_q;
  sac_flags_t         flags_d, flags_q;
  logic [CB:0]        nxe_q, nxx_q, nye_q, nyx_q;
  logic [CB-1:0]      dx_d, dy_d, dx_q, dy_q;
  logic signed [CB-1:0] vx_q, vy_q;

  function automatic logic [CB:0] mag(input logic signed [CB:0] x);
    return x[CB] ? (CB + 1)'(0) - x : x;
  endfunction

  always_comb begin
    al = {a_left_i[CB-1], a_left_i};
    at = {a_top_i[CB-1], a_top_i};
    ar = {a_right_i[CB-1], a_right_i};
    ab = {a_bottom_i[CB-1], a_bottom_i};
    bl = {b_left_i[CB-1], b_left_i};
    bt = {b_top_i[CB-1], b_top_i};
    br = {b_right_i[CB-1], b_right_i};
    bb = {b_bottom_i[CB-1], b_bottom_i};
    vx = {vel_x_i[CB-1], vel_x_i};
    vy = {vel_y_i[CB-1], vel_y_i};
    alv = al + vx;
    arv = ar + vx;
    atv = at + vy;
    abv = ab + vy;
    sl = (alv < al) ? alv : al;
    sr = (arv > ar) ? arv : ar;
    st = (atv < at) ? atv : at;
    sb = (abv > ab) ? abv : ab;
    broad = (sl <= br) && (sr >= bl) && (st <= bb) && (sb >= bt);
    if (vx > 0) begin
      xie = bl - ar;
      xex = br - al;
    end else begin
      xie = br - al;
      xex = bl - ar;
    end
    if (vy > 0) begin
      yie = bt - ab;
      yex = bb - at;
    end else begin
      yie = bb - at;
      yex = bt - ab;
    end
    flags_d.active  = a_movable_i && broad;
    flags_d.vx_zero = (vel_x_i == '0);
    flags_d.vy_zero = (vel_y_i == '0);
    flags_d.xe_neg  = xie[CB] != vel_x_i[CB-1];
    flags_d.xx_neg  = xex[CB] != vel_x_i[CB-1];
    flags_d.ye_neg  = yie[CB] != vel_y_i[CB-1];
    flags_d.yx_neg  = yex[CB] != vel_y_i[CB-1];
    flags_d.xie_neg = xie[CB];
    flags_d.yie_neg = yie[CB];
    dx_d = vel_x_i[CB-1] ? CB'(0) - vel_x_i : vel_x_i;
    dy_d = vel_y_i[CB-1] ? CB'(0) - vel_y_i : vel_y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= take_i;
    end
  end

  always_ff @(posedge clk_i) begin
    flags_q <= flags_d;
    nxe_q   <= mag(xie);
    nxx_q   <= mag(xex);
    nye_q   <= mag(yie);
    nyx_q   <= mag(yex);
    dx_q    <= dx_d;
    dy_q    <= dy_d;
    vx_q    <= vel_x_i;
    vy_q    <= vel_y_i;
  end

  assign valid_o = valid_q;
  assign flags_o = flags_q;
  assign nxe_o   = nxe_q;
  assign nxx_o   = nxx_q;
  assign nye_o   = nye_q;
  assign nyx_o   = nyx_q;
  assign dx_o    = dx_q;
  assign dy_o    = dy_q;
  assign vx_o    = vx_q;
  assign vy_o    = vy_q;

endmodule
`default_nettype wire

// File: src/sac_queue.sv
// Short queue between the front end and the back end, registered read.
`default_nettype none
module sac_queue import sac_pkg::*; #(
  parameter int W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  output logic              full_o,
  output logic              valid_o,
  output logic [W-1:0]      data_o
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  data_q;
  logic          valid_q;
  logic          push, pop;

  assign full_o = (cnt_q == CW'(QUEUE_DEPTH));
  assign push   = push_i && !full_o;
  assign pop    = (cnt_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q   <= cnt_q + CW'(push) - CW'(pop);
      valid_q <= pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_q] <= data_i;
    end
    if (pop) begin
      data_q <= mem[rd_q];
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule
`default_nettype wire

// File: src/sac_div.sv
// Pipelined restoring divider: one quotient bit per stage, result saturated to 2.0.
`default_nettype none
module sac_div #(
  parameter int DW = 32,
  parameter int FB = 16
) (
  input  wire logic          clk_i,
  input  wire logic [DW:0]   n_i,
  input  wire logic [DW-1:0] d_i,
  output logic [FB+1:0]      q_o
);

  logic [DW-1:0] r_q   [FB+1];
  logic [DW-1:0] d_q   [FB+1];
  logic [FB:0]   q_q   [FB+1];
  logic          sat_q [FB+1];
  logic [DW-1:0] r_d   [FB+1];
  logic [FB:0]   q_d   [FB+1];
  logic          ip;
  logic [DW:0]   r0;
  logic [DW:0]   r2, sub;
  logic          ge;

  always_comb begin
    ip = n_i >= {1'b0, d_i};
    r0 = n_i - (ip ? {1'b0, d_i} : '0);
    r_d[0] = r0[DW-1:0];
    q_d[0] = {ip, {FB{1'b0}}};
    r2  = '0;
    sub = '0;
    ge  = 1'b0;
    for (int k = 1; k <= FB; k++) begin
      r2  = {r_q[k-1], 1'b0};
      sub = r2 - {1'b0, d_q[k-1]};
      ge  = r2 >= {1'b0, d_q[k-1]};
      r_d[k] = ge ? sub[DW-1:0] : r2[DW-1:0];
      q_d[k] = q_q[k-1];
      q_d[k][FB-k] = ge;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q[0] <= {1'b0, n_i} >= {1'b0, d_i, 1'b0};
    d_q[0]   <= d_i;
    for (int k = 0; k <= FB; k++) begin
      r_q[k] <= r_d[k];
      q_q[k] <= q_d[k];
    end
    for (int k = 1; k <= FB; k++) begin
      d_q[k]   <= d_q[k-1];
      sat_q[k] <= sat_q[k-1];
    end
  end

  assign q_o = sat_q[FB] ? {2'b10, {FB{1'b0}}} : {1'b0, q_q[FB]};

endmodule
`default_nettype wire

// File: src/sac_back.sv
// Back end: four dividers, interval test, normal choice and slide scaling.
`default_nettype none
module sac_back import sac_pkg::*; #(
  parameter int CB = 32,
  parameter int FB = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire sac_flags_t           flags_i,
  input  wire logic [CB:0]          nxe_i,
  input  wire logic [CB:0]          nxx_i,
  input  wire logic [CB:0]          nye_i,
  input  wire logic [CB:0]          nyx_i,
  input  wire logic [CB-1:0]        dx_i,
  input  wire logic [CB-1:0]        dy_i,
  input  wire logic signed [CB-1:0] vx_i,
  input  wire logic signed [CB-1:0] vy_i,
  output logic                      done_o,
  output logic                      hit_o,
  output logic signed [1:0]         normal_x_o,
  output logic signed [1:0]         normal_y_o,
  output logic [FB:0]               entry_time_o,
  output logic signed [CB-1:0]      new_vel_x_o,
  output logic signed [CB-1:0]      new_vel_y_o
);

  localparam int TW = FB + 4;
  localparam logic signed [TW-1:0] ONE_T = TW'(1 << FB);
  localparam logic signed [TW-1:0] INF_T = TW'(4 << FB);

  // sideband delay matching the divider latency
  logic                 v_q   [FB+1];
  sac_flags_t           f_q   [FB+1];
  logic signed [CB-1:0] svx_q [FB+1];
  logic signed [CB-1:0] svy_q [FB+1];

  logic [FB+1:0] qxe, qxx, qye, qyx;

  sac_div #(.DW(CB), .FB(FB)) u_div_xe (.clk_i(clk_i), .n_i(nxe_i), .d_i(dx_i), .q_o(qxe));
  sac_div #(.DW(CB), .FB(FB)) u_div_xx (.clk_i(clk_i), .n_i(nxx_i), .d_i(dx_i), .q_o(qxx));
  sac_div #(.DW(CB), .FB(FB)) u_div_ye (.clk_i(clk_i), .n_i(nye_i), .d_i(dy_i), .q_o(qye));
  sac_div #(.DW(CB), .FB(FB)) u_div_yx (.clk_i(clk_i), .n_i(nyx_i), .d_i(dy_i), .q_o(qyx));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= FB; i++) v_q[i] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
      for (int i = 1; i <= FB; i++) v_q[i] <= v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    f_q[0]   <= flags_i;
    svx_q[0] <= vx_i;
    svy_q[0] <= vy_i;
    for (int i = 1; i <= FB; i++) begin
      f_q[i]   <= f_q[i-1];
      svx_q[i] <= svx_q[i-1];
      svy_q[i] <= svy_q[i-1];
    end
  end

  function automatic logic signed [TW-1:0] sgn_t(input logic [FB+1:0] q, input logic neg);
    logic signed [TW-1:0] t;
    t = signed'({2'b00, q});
    return neg ? -t : t;
  endfunction

  // interval test
  sac_flags_t           f;
  logic signed [TW-1:0] xe, xx, ye, yx, en, ex;
  logic                 hit_d;
  logic                 ev_q, hit_q, xsel_q, xin_q, yin_q;
  logic [FB:0]          en_q, rem_q;
  logic signed [CB-1:0] evx_q, evy_q;

  always_comb begin
    f  = f_q[FB];
    xe = f.vx_zero ? -INF_T : sgn_t(qxe, f.xe_neg);
    xx = f.vx_zero ?  INF_T : sgn_t(qxx, f.xx_neg);
    ye = f.vy_zero ? -INF_T : sgn_t(qye, f.ye_neg);
    yx = f.vy_zero ?  INF_T : sgn_t(qyx, f.yx_neg);
    en = (xe > ye) ? xe : ye;
    ex = (xx < yx) ? xx : yx;
    hit_d = f.active && !((en > ex) || (xe[TW-1] && ye[TW-1]) || (xe > ONE_T) ||
            (ye > ONE_T)) && (en < ONE_T);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= 1'b0;
    end else begin
      ev_q <= v_q[FB];
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q  <= hit_d;
    xsel_q <= xe > ye;
    xin_q  <= f.xie_neg;
    yin_q  <= f.yie_neg;
    en_q   <= en[FB:0];
    rem_q  <= ONE_T[FB:0] - en[FB:0];
    evx_q  <= svx_q[FB];
    evy_q  <= svy_q[FB];
  end

  // slide product, split at the binary point
  logic signed [CB-1:0] sv;
  logic [CB-1:0]        sm;
  logic                 mv_q, mhit_q, mxsel_q, mxin_q, myin_q, mneg_q;
  logic [FB:0]          men_q;
  logic [CB:0]          ph_q;
  logic [2*FB:0]        pl_q;
  logic signed [CB-1:0] mvx_q, mvy_q;

  always_comb begin
    sv = xsel_q ? evy_q : evx_q;
    sm = sv[CB-1] ? CB'(0) - sv : sv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv_q <= 1'b0;
    end else begin
      mv_q <= ev_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mhit_q  <= hit_q;
    mxsel_q <= xsel_q;
    mxin_q  <= xin_q;
    myin_q  <= yin_q;
    mneg_q  <= sv[CB-1];
    men_q   <= en_q;
    ph_q    <= sm[CB-1:FB] * rem_q;
    pl_q    <= sm[FB-1:0] * rem_q;
    mvx_q   <= evx_q;
    mvy_q   <= evy_q;
  end

  // result register
  logic [CB:0]          psum;
  logic signed [CB-1:0] slide;
  logic                 o_v_q, o_hit_q;
  logic signed [1:0]    o_nx_d, o_ny_d, o_nx_q, o_ny_q;
  logic [FB:0]          o_en_d, o_en_q;
  logic signed [CB-1:0] o_vx_d, o_vy_d, o_vx_q, o_vy_q;

  always_comb begin
    psum  = ph_q + (CB + 1)'(pl_q >> FB);
    slide = mneg_q ? CB'(0) - psum[CB-1:0] : psum[CB-1:0];
    o_nx_d = NRM_NONE;
    o_ny_d = NRM_NONE;
    o_en_d = ONE_T[FB:0];
    o_vx_d = mvx_q;
    o_vy_d = mvy_q;
    if (mhit_q) begin
      o_en_d = men_q;
      if (mxsel_q) begin
        o_nx_d = mxin_q ? NRM_POS : NRM_NEG;
        o_vx_d = '0;
        o_vy_d = slide;
      end else begin
        o_ny_d = myin_q ? NRM_POS : NRM_NEG;
        o_vx_d = slide;
        o_vy_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else begin
      o_v_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    o_hit_q <= mhit_q;
    o_nx_q  <= o_nx_d;
    o_ny_q  <= o_ny_d;
    o_en_q  <= o_en_d;
    o_vx_q  <= o_vx_d;
    o_vy_q  <= o_vy_d;
  end

  assign done_o       = o_v_q;
  assign hit_o        = o_hit_q;
  assign normal_x_o   = o_nx_q;
  assign normal_y_o   = o_ny_q;
  assign entry_time_o = o_en_q;
  assign new_vel_x_o  = o_vx_q;
  assign new_vel_y_o  = o_vy_q;

endmodule
`default_nettype wire

// File: src/swept_aabb_collision_unit.sv
// Top level of the swept box collision unit: front end, queue and back end.
//
// Usage: drive the box pair, velocity and a_movable_i and raise start_i; a
// transfer happens at a rising edge with start_i high and busy_o low. Any
// number of pairs may follow in consecutive cycles, one per cycle.
// Each result shows on the result ports for exactly one cycle with done_o
// high, in the order the pairs came in. The receiver cannot stall.
// The accepting edge loads the front end register; a pair then passes the
// queue write, the queue read register, FRAC_BITS + 1 divider stages (one
// quotient bit per stage, four dividers side by side), the interval test,
// the slide multiply and the result register. Throughput is one pair per
// cycle while busy_o is low; the back end never stops, so busy_o only rises
// if the queue fills.
// Reset empties the queue and clears all valid flags; no result is
// pending after reset.
`default_nettype none
module swept_aabb_collision_unit import sac_pkg::*; #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic signed [COORD_BITS-1:0] a_left_i,
  input  wire logic signed [COORD_BITS-1:0] a_top_i,
  input  wire logic signed [COORD_BITS-1:0] a_right_i,
  input  wire logic signed [COORD_BITS-1:0] a_bottom_i,
  input  wire logic signed [COORD_BITS-1:0] b_left_i,
  input  wire logic signed [COORD_BITS-1:0] b_top_i,
  input  wire logic signed [COORD_BITS-1:0] b_right_i,
  input  wire logic signed [COORD_BITS-1:0] b_bottom_i,
  input  wire logic signed [COORD_BITS-1:0] vel_x_i,
  input  wire logic signed [COORD_BITS-1:0] vel_y_i,
  input  wire logic                         a_movable_i,
  output logic                              done_o,
  output logic                              hit_o,
  output logic signed [1:0]                 normal_x_o,
  output logic signed [1:0]                 normal_y_o,
  output logic [FRAC_BITS:0]                entry_time_o,
  output logic signed [COORD_BITS-1:0]      new_vel_x_o,
  output logic signed [COORD_BITS-1:0]      new_vel_y_o
);

  localparam int CB = COORD_BITS;
  localparam int QW = $bits(sac_flags_t) + 4 * (CB + 1) + 4 * CB;

  logic                 take;
  logic                 f_valid, q_full, q_valid;
  sac_flags_t           f_flags, q_flags;
  logic [CB:0]          f_nxe, f_nxx, f_nye, f_nyx, q_nxe, q_nxx, q_nye, q_nyx;
  logic [CB-1:0]        f_dx, f_dy, q_dx, q_dy;
  logic signed [CB-1:0] f_vx, f_vy, q_vx, q_vy;
  logic [QW-1:0]        q_in, q_out;

  assign take   = start_i && !busy_o;
  assign busy_o = q_full;

  sac_front #(.CB(CB)) u_front (
    .clk_i, .rst_ni, .take_i(take),
    .a_left_i, .a_top_i, .a_right_i, .a_bottom_i,
    .b_left_i, .b_top_i, .b_right_i, .b_bottom_i,
    .vel_x_i, .vel_y_i, .a_movable_i,
    .valid_o(f_valid), .flags_o(f_flags),
    .nxe_o(f_nxe), .nxx_o(f_nxx), .nye_o(f_nye), .nyx_o(f_nyx),
    .dx_o(f_dx), .dy_o(f_dy), .vx_o(f_vx), .vy_o(f_vy)
  );

  assign q_in = {f_flags, f_nxe, f_nxx, f_nye, f_nyx, f_dx, f_dy, f_vx, f_vy};

  sac_queue #(.W(QW)) u_queue (
    .clk_i, .rst_ni, .push_i(f_valid), .data_i(q_in),
    .full_o(q_full), .valid_o(q_valid), .data_o(q_out)
  );

  assign {q_flags, q_nxe, q_nxx, q_nye, q_nyx, q_dx, q_dy, q_vx, q_vy} = q_out;

  sac_back #(.CB(CB), .FB(FRAC_BITS)) u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .flags_i(q_flags),
    .nxe_i(q_nxe), .nxx_i(q_nxx), .nye_i(q_nye), .nyx_i(q_nyx),
    .dx_i(q_dx), .dy_i(q_dy), .vx_i(q_vx), .vy_i(q_vy),
    .done_o, .hit_o, .normal_x_o, .normal_y_o, .entry_time_o,
    .new_vel_x_o, .new_vel_y_o
  );

endmodule
`default_nettype wire

// File: tb/swept_aabb_collision_unit_test.sv
// Self-checking testbench for the swept box collision unit.
`default_nettype none
module swept_aabb_collision_unit_test;
  import sac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 32;
  localparam int FB = 16;
  localparam longint ONE_T = 64'sd1 << FB;
  localparam longint TIME_INF = 4 * ONE_T;
  localparam int LATENCY = FB + 6;

  typedef struct {
    logic signed [CB-1:0] al, at, ar, ab, bl, bt, br, bb, vx, vy;
    logic mov;
  } pair_t;

  typedef struct {
    logic hit;
    logic signed [1:0] nx, ny;
    logic [FB:0] entry;
    logic signed [CB-1:0] nvx, nvy;
  } contact_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy, done;
  pair_t drv = '{default: '0};
  logic hit;
  logic signed [1:0] nrm_x, nrm_y;
  logic [FB:0] t_entry;
  logic signed [CB-1:0] nvel_x, nvel_y;

  contact_t pending_contacts[$];
  int errors = 0;
  int idle_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  swept_aabb_collision_unit #(.COORD_BITS(CB), .FRAC_BITS(FB)) uut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .a_left_i(drv.al), .a_top_i(drv.at), .a_right_i(drv.ar), .a_bottom_i(drv.ab),
    .b_left_i(drv.bl), .b_top_i(drv.bt), .b_right_i(drv.br), .b_bottom_i(drv.bb),
    .vel_x_i(drv.vx), .vel_y_i(drv.vy), .a_movable_i(drv.mov),
    .done_o(done), .hit_o(hit), .normal_x_o(nrm_x), .normal_y_o(nrm_y),
    .entry_time_o(t_entry), .new_vel_x_o(nvel_x), .new_vel_y_o(nvel_y)
  );

  function automatic longint time_quot(longint num, longint den);
    longint n, d, r, fr, ip, q;
    n = num < 0 ? -num : num;
    d = den < 0 ? -den : den;
    if (n >= 2 * d) q = 2 * ONE_T;
    else begin
      ip = (n >= d) ? 1 : 0;
      r = n - ip * d;
      fr = 0;
      for (int i = 0; i < FB; i++) begin
        r = r << 1;
        fr = fr << 1;
        if (r >= d) begin
          r = r - d;
          fr = fr | 1;
        end
      end
      q = (ip << FB) | fr;
    end
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic longint slide(longint v, longint rem);
    longint m, p;
    m = v < 0 ? -v : v;
    p = (m >>> FB) * rem + (((m & (ONE_T - 1)) * rem) >>> FB);
    return v < 0 ? -p : p;
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    contact_t c;
    longint al, at, ar, ab, bl, bt, br, bb, vx, vy;
    longint sl, sr, st, sb, xie, xex, yie, yex, xe, xx, ye, yx, en, ex;
    longint nvx, nvy;
    al = p.al; at = p.at; ar = p.ar; ab = p.ab;
    bl = p.bl; bt = p.bt; br = p.br; bb = p.bb;
    vx = p.vx; vy = p.vy;
    c.hit = 1'b0; c.nx = NRM_NONE; c.ny = NRM_NONE;
    c.entry = ONE_T[FB:0];
    nvx = vx; nvy = vy;
    sl = (al + vx < al) ? al + vx : al;
    sr = (ar + vx > ar) ? ar + vx : ar;
    st = (at + vy < at) ? at + vy : at;
    sb = (ab + vy > ab) ? ab + vy : ab;
    if (p.mov && sl <= br && sr >= bl && st <= bb && sb >= bt) begin
      if (vx > 0) begin xie = bl - ar; xex = br - al; end
      else begin xie = br - al; xex = bl - ar; end
      if (vy > 0) begin yie = bt - ab; yex = bb - at; end
      else begin yie = bb - at; yex = bt - ab; end
      if (vx == 0) begin xe = -TIME_INF; xx = TIME_INF; end
      else begin xe = time_quot(xie, vx); xx = time_quot(xex, vx); end
      if (vy == 0) begin ye = -TIME_INF; yx = TIME_INF; end
      else begin ye = time_quot(yie, vy); yx = time_quot(yex, vy); end
      en = xe > ye ? xe : ye;
      ex = xx < yx ? xx : yx;
      if (!(en > ex || (xe < 0 && ye < 0) || xe > ONE_T || ye > ONE_T) && en < ONE_T) begin
        c.hit = 1'b1;
        c.entry = en[FB:0];
        if (xe > ye) begin
          c.nx = (xie < 0) ? NRM_POS : NRM_NEG;
          nvx = 0;
          nvy = slide(vy, ONE_T - en);
        end else begin
          c.ny = (yie < 0) ? NRM_POS : NRM_NEG;
          nvx = slide(vx, ONE_T - en);
          nvy = 0;
        end
      end
    end
    c.nvx = nvx[CB-1:0];
    c.nvy = nvy[CB-1:0];
    return c;
  endfunction

  // one transfer per call; start stays high when items come back to back
  task automatic send_pair(pair_t p);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    drv <= p;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_contacts.push_back(predict_contact(p));
  endtask

  always @(posedge clk) begin
    contact_t e;
    if (done) begin
      if (pending_contacts.size() == 0) begin
        $display("%0t: unexpected result hit=%0b", $time, hit);
        errors++;
      end else begin
        e = pending_contacts.pop_front();
        if (hit !== e.hit || nrm_x !== e.nx || nrm_y !== e.ny ||
            t_entry !== e.entry || nvel_x !== e.nvx || nvel_y !== e.nvy) begin
          $display("%0t: mismatch exp hit=%0b n=(%0d,%0d) t=%0d v=(%0d,%0d)",
                   $time, e.hit, e.nx, e.ny, e.entry, e.nvx, e.nvy);
          $display("%0t:          got hit=%0b n=(%0d,%0d) t=%0d v=(%0d,%0d)",
                   $time, hit, nrm_x, nrm_y, t_entry, nvel_x, nvel_y);
          errors++;
        end
      end
    end
  end

  function automatic logic signed [CB-1:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(8 << FB)) - (4 << FB);
      2: return $signed($urandom_range(64)) - 32;
      default: return $signed(($urandom_range(16) - 8)) <<< FB;
    endcase
  endfunction

  // B is a box near the origin; A heads toward it with about twice its offset per axis, or zero velocity on an axis
  function automatic pair_t rand_approach();
    pair_t p;
    int w, h;
    w = $urandom_range(4 << FB, 1);
    h = $urandom_range(4 << FB, 1);
    p.bl = $signed($urandom_range(4 << FB)) - (2 << FB);
    p.bt = $signed($urandom_range(4 << FB)) - (2 << FB);
    p.br = p.bl + $urandom_range(4 << FB);
    p.bb = p.bt + $urandom_range(4 << FB);
    p.al = p.bl + $signed($urandom_range(16 << FB)) - (8 << FB);
    p.at = p.bt + $signed($urandom_range(16 << FB)) - (8 << FB);
    p.ar = p.al + w;
    p.ab = p.at + h;
    p.vx = ($urandom_range(5) == 0) ? 0 : (p.bl - p.al) * 2 + $signed($urandom_range(4 << FB)) - (2 << FB);
    p.vy = ($urandom_range(5) == 0) ? 0 : (p.bt - p.at) * 2 + $signed($urandom_range(4 << FB)) - (2 << FB);
    p.mov = $urandom_range(9) != 0;
    return p;
  endfunction

  function automatic pair_t rand_noise();
    pair_t p;
    p.al = rand_coord(); p.at = rand_coord(); p.ar = rand_coord(); p.ab = rand_coord();
    p.bl = rand_coord(); p.bt = rand_coord(); p.br = rand_coord(); p.bb = rand_coord();
    p.vx = rand_coord(); p.vy = rand_coord();
    p.mov = $urandom_range(1);
    return p;
  endfunction

  function automatic pair_t mk(int al, int at, int ar, int ab, int bl, int bt,
                               int br, int bb, int vx, int vy, logic mov);
    pair_t p;
    p.al = al <<< FB; p.at = at <<< FB; p.ar = ar <<< FB; p.ab = ab <<< FB;
    p.bl = bl <<< FB; p.bt = bt <<< FB; p.br = br <<< FB; p.bb = bb <<< FB;
    p.vx = vx <<< FB; p.vy = vy <<< FB; p.mov = mov;
    return p;
  endfunction

  task automatic test_directed();
    pair_t p;
    send_pair(mk(0, 0, 1, 1, 3, 0, 4, 1, 4, 0, 1));      // x hit from the left
    send_pair(mk(5, 0, 6, 1, 3, 0, 4, 1, -4, 0, 1));     // x hit from the right
    send_pair(mk(0, 0, 1, 1, 0, 3, 1, 4, 0, 4, 1));      // y hit from above
    send_pair(mk(0, 5, 1, 6, 0, 3, 1, 4, 0, -4, 1));     // y hit from below
    send_pair(mk(0, 0, 1, 1, 3, 3, 4, 4, 4, 4, 1));      // diagonal, equal entries
    send_pair(mk(0, 0, 1, 1, 3, 0, 4, 1, 4, 2, 0));      // not movable
    send_pair(mk(0, 0, 1, 1, 3, 0, 4, 1, 0, 0, 1));      // zero velocity
    send_pair(mk(0, 0, 1, 1, 3, 0, 4, 1, 2, 0, 1));      // touching edges
    send_pair(mk(0, 0, 1, 1, 3, 0, 4, 1, 1, 0, 1));      // no broadphase overlap
    send_pair(mk(0, 0, 1, 1, 2, 0, 3, 1, 1, 0, 1));      // entry exactly one
    send_pair(mk(0, 0, 2, 2, 1, 1, 3, 3, 1, 1, 1));      // already overlapping
    send_pair(mk(0, 0, 1, 1, 3, 5, 4, 6, 4, 1, 1));      // miss: no broadphase overlap on y
    send_pair(mk(3, 0, 1, 1, 3, 0, 4, 1, 4, 0, 1));      // inverted box
    p = '{al: 32'sh8000_0000, at: 32'sh8000_0000, ar: 32'sh7fff_ffff, ab: 32'sh7fff_ffff,
          bl: 32'sh8000_0000, bt: 32'sh8000_0000, br: 32'sh7fff_ffff, bb: 32'sh7fff_ffff,
          vx: 32'sh7fff_ffff, vy: 32'sh8000_0000, mov: 1'b1};
    send_pair(p);
    p.vx = 32'sh8000_0000; p.vy = 32'sh7fff_ffff;
    send_pair(p);
    p = '{al: -1, at: -1, ar: 0, ab: 0, bl: 1, bt: 1, br: 2, bb: 2,
          vx: 32'sh7fff_ffff, vy: 32'sh7fff_ffff, mov: 1'b1};
    send_pair(p);
    p = '{al: 32'sh7fff_fff0, at: 0, ar: 32'sh7fff_ffff, ab: 1, bl: 32'sh8000_0000,
          bt: 0, br: 32'sh8000_0010, bb: 1, vx: 32'sh8000_0000, vy: 0, mov: 1'b1};
    send_pair(p);
  endtask

  task automatic test_random(int n, int pct);
    idle_pct = pct;
    for (int i = 0; i < n; i++)
      send_pair(($urandom_range(3) == 0) ? rand_noise() : rand_approach());
    idle_pct = 0;
  endtask

  initial begin
    int guard;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300, 0);
    test_random(150, 70);
    test_random(100, 18);
    test_random(300, 0);
    start <= 1'b0;
    guard = 0;
    while (pending_contacts.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (errors == 0 && pending_contacts.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire
